@@ design/deq_pkg.sv @@
// Package for the double-ended queue: sizes, codes, shared types and pointer helpers.
`default_nettype none

package deq_pkg;

    // Queue depth and derived widths
    localparam int DEPTH  = 16;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW     = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int CNT_W  = 5;

    // Value shown on both ends when the queue holds nothing
    localparam logic signed [WORD_W-1:0] EMPTY_MARK = 32'sd404;

    typedef logic [AW-1:0] t_addr;
    typedef logic [FW-1:0] t_fill;
    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        FN_PUSH_BACK  = 2'd0,
        FN_PUSH_FRONT = 2'd1,
        FN_POP_BACK   = 2'd2,
        FN_POP_FRONT  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } t_state;

    // Slot memory request: one write port, two read ports
    typedef struct packed {
        logic  wr_en;
        t_addr wr_addr;
        t_word wr_data;
        logic  rd_en;
        t_addr rd_addr_front;
        t_addr rd_addr_back;
    } t_mem_req;

    // Result handed from the controller to the output stage
    typedef struct packed {
        logic             load;
        logic             empty;
        logic [CNT_W-1:0] count;
        t_status          status;
    } t_res;

    // Circular pointer step forward
    function automatic t_addr wrap_inc(input t_addr p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    // Circular pointer step backward
    function automatic t_addr wrap_dec(input t_addr p);
        return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

endpackage

`default_nettype wire

@@ design/deq_if.sv @@
// Valid/ready channel interfaces for the queue's operation and result words.
`default_nettype none

interface deq_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [31:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface deq_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [4:0]         count;
    logic [1:0]         status;

    modport source (output valid, output front_value, output back_value,
                    output count, output status, input ready);
    modport sink   (input valid, input front_value, input back_value,
                    input count, input status, output ready);
endinterface

`default_nettype wire

@@ design/deq_mem.sv @@
// Slot storage: one write port and two registered read ports.
`default_nettype none

module deq_mem (
    input  wire logic              i_clk,
    input  wire deq_pkg::t_mem_req i_req,
    output deq_pkg::t_word         o_rd_front,
    output deq_pkg::t_word         o_rd_back
);
    import deq_pkg::*;

    t_word r_slots [DEPTH];
    t_word r_rd_front;
    t_word r_rd_back;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_slots[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Read ports, registered; data holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_front <= r_slots[i_req.rd_addr_front];
            r_rd_back  <= r_slots[i_req.rd_addr_back];
        end
    end

    assign o_rd_front = r_rd_front;
    assign o_rd_back  = r_rd_back;

endmodule

`default_nettype wire

@@ design/deq_ctrl.sv @@
// Queue controller: pointers, fill count, status and the access sequencer.
`default_nettype none

module deq_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    deq_in_if.sink           i_in,
    input  wire logic        i_out_stall,
    output deq_pkg::t_mem_req o_mem,
    output deq_pkg::t_res    o_res
);
    import deq_pkg::*;

    t_state  r_state, n_state;
    t_addr   r_front, n_front;
    t_addr   r_back, n_back;
    t_fill   r_fill, n_fill;
    t_status r_status, n_status;

    logic  is_push;
    logic  full;
    logic  empty;
    t_func func;

    assign func    = t_func'(i_in.func);
    assign is_push = (func == FN_PUSH_BACK) || (func == FN_PUSH_FRONT);
    assign full    = (r_fill == FW'(DEPTH));
    assign empty   = (r_fill == '0);

    // State and queue registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_front  <= '0;
            r_back   <= '0;
            r_fill   <= '0;
            r_status <= STAT_OK;
        end else begin
            r_state  <= n_state;
            r_front  <= n_front;
            r_back   <= n_back;
            r_fill   <= n_fill;
            r_status <= n_status;
        end
    end

    // Next state, pointer update and memory requests
    always_comb begin
        n_state  = r_state;
        n_front  = r_front;
        n_back   = r_back;
        n_fill   = r_fill;
        n_status = r_status;

        i_in.ready = 1'b0;

        o_mem               = '0;
        o_mem.wr_data       = i_in.value;
        o_mem.rd_addr_front = r_front;
        o_mem.rd_addr_back  = wrap_dec(r_back);

        o_res.load   = 1'b0;
        o_res.empty  = empty;
        o_res.count  = CNT_W'(r_fill);
        o_res.status = r_status;

        case (r_state)
            ST_IDLE: begin
                // ready is high here, so valid alone marks the accept
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_state  = ST_READ;
                    n_status = STAT_OK;
                    if (is_push && full) begin
                        n_status = STAT_FULL;
                    end else if (!is_push && empty) begin
                        n_status = STAT_EMPTY;
                    end else begin
                        case (func)
                            FN_PUSH_BACK: begin
                                o_mem.wr_en   = 1'b1;
                                o_mem.wr_addr = r_back;
                                n_back        = wrap_inc(r_back);
                                n_fill        = r_fill + FW'(1);
                            end
                            FN_PUSH_FRONT: begin
                                o_mem.wr_en   = 1'b1;
                                o_mem.wr_addr = wrap_dec(r_front);
                                n_front       = wrap_dec(r_front);
                                n_fill        = r_fill + FW'(1);
                            end
                            FN_POP_BACK: begin
                                n_back = wrap_dec(r_back);
                                n_fill = r_fill - FW'(1);
                            end
                            FN_POP_FRONT: begin
                                n_front = wrap_inc(r_front);
                                n_fill  = r_fill - FW'(1);
                            end
                            default: begin
                                n_fill = r_fill;
                            end
                        endcase
                    end
                end
            end
            // Write landed at the accept edge, so both ends read current data
            ST_READ: begin
                o_mem.rd_en = 1'b1;
                n_state     = ST_LOAD;
            end
            ST_LOAD: begin
                if (!i_out_stall) begin
                    o_res.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/double_ended_queue.sv @@
// Top level of the double-ended queue: controller, slot memory and result register.
//
// Usage:
//   i_in carries one operation word per handshake: func (0 push back,
//   1 push front, 2 pop back, 3 pop front) and value (pushed word).
//   o_out returns exactly one result word per operation: front and back
//   elements (404 when empty), element count and status (0 done, 1 pop on
//   empty ignored, 2 push on full dropped).
// Timing:
//   An operation passes through accept with the memory write, the read of
//   both ends from the slot memory, and the load of the result register,
//   which waits while o_out is stalled. The next operation is taken in the
//   cycle after the result is loaded, so the controller handles only one
//   operation at a time.
// Reset:
//   Synchronous, active low. The queue comes up empty with both pointers
//   and the count at zero and no result pending; slot contents are not
//   cleared.
// Backpressure:
//   While o_out is stalled the result stays in its register; one further
//   operation may be accepted and waits for the register before loading.
`default_nettype none

module double_ended_queue (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    deq_in_if.sink    i_in,
    deq_out_if.source o_out
);
    import deq_pkg::*;

    t_mem_req mem_req;
    t_res     res;
    t_word    rd_front;
    t_word    rd_back;
    logic     out_stall;

    logic             r_valid;
    t_word            r_front_value;
    t_word            r_back_value;
    logic [CNT_W-1:0] r_count;
    t_status          r_status;

    assign out_stall = r_valid && !o_out.ready;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_out_stall (out_stall),
        .o_mem       (mem_req),
        .o_res       (res)
    );

    deq_mem u_mem (
        .i_clk      (i_clk),
        .i_req      (mem_req),
        .o_rd_front (rd_front),
        .o_rd_back  (rd_back)
    );

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (res.load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload; empty queue shows the marker on both ends
    always_ff @(posedge i_clk) begin
        if (res.load) begin
            r_front_value <= res.empty ? EMPTY_MARK : rd_front;
            r_back_value  <= res.empty ? EMPTY_MARK : rd_back;
            r_count       <= res.count;
            r_status      <= res.status;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.front_value = r_front_value;
    assign o_out.back_value  = r_back_value;
    assign o_out.count       = r_count;
    assign o_out.status      = r_status;

`ifndef SYNTHESIS
    // A dropped push only happens on a full queue
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.load && res.status == STAT_FULL) |-> (res.count == CNT_W'(DEPTH)))
        else $error("full status with count below depth");

    // An ignored pop leaves an empty queue showing the marker
    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.load && res.status == STAT_EMPTY)
            |=> (r_count == '0 && r_front_value == EMPTY_MARK
                 && r_back_value == EMPTY_MARK))
        else $error("empty status without empty result");

    // One operation in flight: no new word right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("operation accepted while another is in flight");

    // Result register is not overwritten while stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.load |-> !out_stall)
        else $error("result loaded over a pending word");
`endif

endmodule

`default_nettype wire

@@ dv/tb_double_ended_queue.sv @@
// Testbench for the double-ended queue: directed and random operations checked against a predictor.
module tb_double_ended_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    // One operation word and one expected result snapshot
    typedef struct {
        t_func func;
        t_word value;
    } t_deq_op;

    typedef struct {
        t_word            front;
        t_word            back;
        logic [CNT_W-1:0] count;
        t_status          status;
    } t_deq_view;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    deq_in_if  in_ch();
    deq_out_if out_ch();

    double_ended_queue u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Pending operations and expected results
    t_deq_op   op_backlog[$];
    t_deq_view queued_views[$];
    int        n_errors = 0;

    // Predictor copy of the queue
    t_word slot_copy [DEPTH];
    t_addr head_idx = '0;
    t_addr tail_idx = '0;
    int    held = 0;

    // Cycle count, quiet window and receiver hold-off
    int   cyc = 0;
    logic quiet = 1'b0;
    logic hold_off = 1'b0;
    logic send_gap;
    logic recv_gap;
    t_deq_op next_op;

    function automatic t_addr ring_next(input t_addr p);
        if (int'(p) == DEPTH - 1) return '0;
        return p + t_addr'(1);
    endfunction

    function automatic t_addr ring_prev(input t_addr p);
        if (p == '0) return t_addr'(DEPTH - 1);
        return p - t_addr'(1);
    endfunction

    // Apply one accepted word to the predictor and queue its result
    function automatic void apply_deque_op(input t_func f, input t_word v);
        t_deq_view view;
        view.status = STAT_OK;
        case (f)
            FN_PUSH_BACK, FN_PUSH_FRONT: begin
                if (held >= DEPTH) begin
                    view.status = STAT_FULL;
                end else if (f == FN_PUSH_BACK) begin
                    slot_copy[tail_idx] = v;
                    tail_idx = ring_next(tail_idx);
                    held++;
                end else begin
                    head_idx = ring_prev(head_idx);
                    slot_copy[head_idx] = v;
                    held++;
                end
            end
            default: begin
                if (held == 0) begin
                    view.status = STAT_EMPTY;
                end else if (f == FN_POP_BACK) begin
                    tail_idx = ring_prev(tail_idx);
                    held--;
                end else begin
                    head_idx = ring_next(head_idx);
                    held--;
                end
            end
        endcase
        if (held != 0) begin
            view.front = slot_copy[head_idx];
            view.back  = slot_copy[ring_prev(tail_idx)];
        end else begin
            view.front = EMPTY_MARK;
            view.back  = EMPTY_MARK;
        end
        view.count = held[CNT_W-1:0];
        queued_views.insert(queued_views.size(), view);
    endfunction

    task automatic add_op(input t_func f, input t_word v);
        t_deq_op op;
        op.func  = f;
        op.value = v;
        op_backlog.insert(op_backlog.size(), op);
    endtask

    function automatic t_word pick_value();
        case ($urandom_range(11))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return EMPTY_MARK;
            default: return t_word'($urandom);
        endcase
    endfunction

    // Known levels on all block inputs from time zero
    initial begin
        in_ch.valid  = 1'b0;
        in_ch.func   = '0;
        in_ch.value  = '0;
        out_ch.ready = 1'b0;
    end

    // Cycle counter, no-idle window and long receiver stall
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        quiet <= (cyc >= 1500 && cyc < 2100);
        hold_off <= (cyc >= 4000 && cyc < 4300);
    end

    // Driver: present backlog words, predict on each accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                apply_deque_op(t_func'(in_ch.func), in_ch.value);
            if (!in_ch.valid || in_ch.ready) begin
                send_gap = !quiet && !hold_off && ($urandom_range(99) < 33);
                if (op_backlog.size() > 0 && !send_gap) begin
                    next_op = op_backlog[0];
                    op_backlog.delete(0);
                    in_ch.valid <= 1'b1;
                    in_ch.func  <= next_op.func;
                    in_ch.value <= next_op.value;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random ready, compare each result word with the oldest snapshot
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (queued_views.size() == 0) begin
                    $error("result word with nothing expected");
                    n_errors++;
                end else begin
                    t_deq_view exp_v;
                    exp_v = queued_views[0];
                    queued_views.delete(0);
                    if (out_ch.front_value !== exp_v.front) begin
                        $error("front_value: expected %0d, got %0d", exp_v.front,
                               out_ch.front_value);
                        n_errors++;
                    end
                    if (out_ch.back_value !== exp_v.back) begin
                        $error("back_value: expected %0d, got %0d", exp_v.back,
                               out_ch.back_value);
                        n_errors++;
                    end
                    if (out_ch.count !== exp_v.count) begin
                        $error("count: expected %0d, got %0d", exp_v.count, out_ch.count);
                        n_errors++;
                    end
                    if (out_ch.status !== exp_v.status) begin
                        $error("status: expected %0d, got %0d", exp_v.status,
                               out_ch.status);
                        n_errors++;
                    end
                end
            end
            recv_gap = !quiet && ($urandom_range(99) < 33);
            out_ch.ready <= !hold_off && !recv_gap;
        end
    end

    // Stimulus and end of run
    initial begin
        int      mode;
        int      seg_len;
        int      n_random;
        int      roll;
        t_func   f;

        // Directed: extremes, both pops on empty, fill up, both pushes on full
        add_op(FN_PUSH_BACK, 32'sh7fffffff);
        add_op(FN_PUSH_FRONT, 32'sh80000000);
        add_op(FN_POP_BACK, 32'sd0);
        add_op(FN_POP_FRONT, -32'sd1);
        add_op(FN_POP_BACK, 32'sd5);
        add_op(FN_POP_FRONT, 32'sd6);
        add_op(FN_PUSH_FRONT, EMPTY_MARK);
        add_op(FN_POP_BACK, 32'sd0);
        for (int k = 0; k < DEPTH; k++)
            add_op((k % 2) ? FN_PUSH_FRONT : FN_PUSH_BACK,
                   (k % 3 == 0) ? -32'sd1 : t_word'(k * 32'h1111_1111));
        add_op(FN_PUSH_BACK, 32'sh7fffffff);
        add_op(FN_PUSH_FRONT, 32'sh80000000);

        // Random: segments biased to fill, drain or hover
        n_random = 0;
        while (n_random < 1950) begin
            mode = $urandom_range(2);
            seg_len = $urandom_range(4, 40);
            for (int k = 0; k < seg_len; k++) begin
                roll = $urandom_range(99);
                case (mode)
                    0: f = (roll < 80) ? t_func'($urandom_range(1))
                                       : t_func'($urandom_range(3, 2));
                    1: f = (roll < 80) ? t_func'($urandom_range(3, 2))
                                       : t_func'($urandom_range(1));
                    default: f = t_func'($urandom_range(3));
                endcase
                add_op(f, pick_value());
            end
            n_random += seg_len;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_backlog.size() > 0 || in_ch.valid) @(posedge i_clk);
        while (queued_views.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
design/deq_pkg.sv
design/deq_if.sv
design/deq_mem.sv
design/deq_ctrl.sv
design/double_ended_queue.sv
dv/tb_double_ended_queue.sv
